@@ hw/rtl/escaped_hashed_frame_transmitter_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the framer
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_HASHED_FRAME_TRANSMITTER_MACROS_SVH
`define ESCAPED_HASHED_FRAME_TRANSMITTER_MACROS_SVH

// property holds at every edge
`define EHFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// pre at one edge implies post at the next edge
`define EHFT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/ehft_pkg.sv @@
// ----------------------------------------------------------------------------
// ehft_pkg
// Types, codes and constants shared by the framer modules.
// ----------------------------------------------------------------------------
package ehft_pkg;

    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [MODE_W-1:0] MODE_DATA    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLAG    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HASH    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HASH_START_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_START_HIGH = 2'd1;

    localparam logic [BYTE_W-1:0] HASH_START_LOW_RST  = 8'h6B;
    localparam logic [BYTE_W-1:0] HASH_START_HIGH_RST = 8'h39;

    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] RESERVED_A = 8'h03;
    localparam logic [BYTE_W-1:0] RESERVED_B = 8'h1A;
    localparam logic [BYTE_W-1:0] RESERVED_C = 8'h1C;

    // one queued unit of work: one or two unescaped line bytes
    typedef struct packed {
        logic              two_bytes;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte0;
    } t_entry;

    function automatic logic is_reserved(input logic [BYTE_W-1:0] b);
        return b inside {RESERVED_A, RESERVED_B, RESERVED_C, ESC_BYTE};
    endfunction

endpackage

@@ hw/rtl/escaped_hashed_frame_transmitter.sv @@
// ----------------------------------------------------------------------------
// escaped_hashed_frame_transmitter
// The first line byte of an item passes the entry queue, then the output register.
// One line byte per cycle while the queue holds an entry and m_tready allows;
// an item yields 0 to 4 line bytes, set by its mode and escaped byte count.
// Input accepted every cycle while the entry queue has room.
// Reset (synchronous, active low): hash and start registers to 0x6B/0x39,
// queue and output empty.
// ----------------------------------------------------------------------------
module escaped_hashed_frame_transmitter #(
    parameter int QUEUE_DEPTH = ehft_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ehft_pkg::BYTE_W-1:0]     s_tdata,    // [7:0] value
    input  logic [ehft_pkg::MODE_W-1:0]     s_tuser,    // [1:0] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ehft_pkg::BYTE_W-1:0]     m_tdata,    // [7:0] line_byte
    output logic                            m_tlast,    // last_of_item
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ehft_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ehft_pkg::BYTE_W-1:0]     i_cfg_data
);

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    ehft_pkg::t_entry w_entry;
    ehft_pkg::t_entry w_head;

    ehft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    ehft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ehft_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/ehft_front.sv @@
// ----------------------------------------------------------------------------
// ehft_front
// Accepts input transactions, keeps the running hash and start registers,
// and pushes one queue entry per item that produces line bytes.
// ----------------------------------------------------------------------------
module ehft_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ehft_pkg::BYTE_W-1:0]     s_tdata,    // [7:0] value
    input  logic [ehft_pkg::MODE_W-1:0]     s_tuser,    // [1:0] mode
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ehft_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ehft_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                            i_full,
    output logic                            o_push,
    output ehft_pkg::t_entry                o_entry
);

    logic [ehft_pkg::BYTE_W-1:0]   r_start_low, n_start_low;
    logic [ehft_pkg::BYTE_W-1:0]   r_start_high, n_start_high;
    logic [ehft_pkg::BYTE_W-1:0]   r_hash_low, n_hash_low;
    logic [ehft_pkg::BYTE_W-1:0]   r_hash_high, n_hash_high;
    logic [2*ehft_pkg::BYTE_W-1:0] w_prod;
    logic [ehft_pkg::BYTE_W-1:0]   w_l;
    logic [ehft_pkg::BYTE_W-1:0]   w_h;
    logic                          w_acc;
    logic                          w_cfg;

    assign s_tready    = !i_full;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = s_tvalid && s_tready;
    assign w_cfg       = i_cfg_valid && o_cfg_ready;

    assign w_prod = r_hash_low * r_hash_high;
    assign w_l    = w_prod[ehft_pkg::BYTE_W-1:0];
    assign w_h    = w_l ^ r_hash_high;

    always_comb begin
        n_start_low  = r_start_low;
        n_start_high = r_start_high;
        n_hash_low   = r_hash_low;
        n_hash_high  = r_hash_high;
        o_push       = 1'b0;
        o_entry      = '0;
        if (w_cfg) begin
            case (i_cfg_index)
                ehft_pkg::REG_HASH_START_LOW:  n_start_low  = i_cfg_data;
                ehft_pkg::REG_HASH_START_HIGH: n_start_high = i_cfg_data;
                default: ;
            endcase
        end
        case (s_tuser)
            ehft_pkg::MODE_DATA: begin
                o_push            = w_acc;
                o_entry.two_bytes = 1'b0;
                o_entry.byte0     = s_tdata;
                o_entry.byte1     = s_tdata;
                if (w_acc) begin
                    n_hash_low  = w_l ^ s_tdata;
                    n_hash_high = w_h ^ s_tdata;
                end
            end
            ehft_pkg::MODE_FLAG: begin
                o_push            = w_acc;
                o_entry.two_bytes = 1'b1;
                o_entry.byte0     = s_tdata;
                o_entry.byte1     = s_tdata;
            end
            ehft_pkg::MODE_HASH: begin
                o_push            = w_acc;
                o_entry.two_bytes = 1'b1;
                o_entry.byte0     = r_hash_low;
                o_entry.byte1     = r_hash_high;
            end
            default: begin
                if (w_acc) begin
                    n_hash_low  = r_start_low;
                    n_hash_high = r_start_high;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_low  <= ehft_pkg::HASH_START_LOW_RST;
            r_start_high <= ehft_pkg::HASH_START_HIGH_RST;
            r_hash_low   <= ehft_pkg::HASH_START_LOW_RST;
            r_hash_high  <= ehft_pkg::HASH_START_HIGH_RST;
        end else begin
            r_start_low  <= n_start_low;
            r_start_high <= n_start_high;
            r_hash_low   <= n_hash_low;
            r_hash_high  <= n_hash_high;
        end
    end

endmodule

@@ hw/rtl/ehft_queue.sv @@
// ----------------------------------------------------------------------------
// ehft_queue
// Small first-in first-out queue of entries between front and back.
// ----------------------------------------------------------------------------
module ehft_queue #(
    parameter int DEPTH = ehft_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ehft_pkg::t_entry i_entry,
    input  logic             i_pop,
    output ehft_pkg::t_entry o_head,
    output logic             o_full,
    output logic             o_empty
);

`include "escaped_hashed_frame_transmitter_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ehft_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `EHFT_ASSERT(a_no_push_full, !(i_push && o_full), "push into full queue")
    `EHFT_ASSERT(a_no_pop_empty, !(i_pop && o_empty), "pop from empty queue")
    `EHFT_ASSERT(a_count_range, r_count <= CNT_W'(DEPTH), "queue count overflow")

endmodule

@@ hw/rtl/ehft_back.sv @@
// ----------------------------------------------------------------------------
// ehft_back
// Walks the head entry byte by byte, escapes reserved bytes and drives the
// registered output stream.
// ----------------------------------------------------------------------------
module ehft_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ehft_pkg::t_entry            i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ehft_pkg::BYTE_W-1:0] m_tdata,    // [7:0] line_byte
    output logic                        m_tlast     // last_of_item
);

`include "escaped_hashed_frame_transmitter_macros.svh"

    logic                        r_out_valid, n_out_valid;
    logic [ehft_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                        r_out_last, n_out_last;
    logic                        r_idx, n_idx;
    logic                        r_esc, n_esc;
    logic [ehft_pkg::BYTE_W-1:0] w_cur;
    logic                        w_rsv;
    logic                        w_done;
    logic                        w_fin;
    logic                        w_step;

    assign w_cur  = r_idx ? i_head.byte1 : i_head.byte0;
    assign w_rsv  = ehft_pkg::is_reserved(w_cur);
    assign w_done = r_esc || !w_rsv;
    assign w_fin  = w_done && (r_idx || !i_head.two_bytes);
    assign w_step = (!r_out_valid || m_tready) && !i_empty;
    assign o_pop  = w_step && w_fin;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_idx       = r_idx;
        n_esc       = r_esc;
        if (w_step) begin
            n_out_valid = 1'b1;
            n_out_last  = w_fin;
            if (r_esc) begin
                n_out_byte = w_cur ^ ehft_pkg::ESC_BYTE;
            end else if (w_rsv) begin
                n_out_byte = ehft_pkg::ESC_BYTE;
            end else begin
                n_out_byte = w_cur;
            end
            n_esc = !w_done;
            if (w_done) begin
                n_idx = !w_fin;
            end
        end else if (m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 1'b0;
            r_esc       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_esc       <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_byte;
    assign m_tlast  = r_out_last;

    `EHFT_ASSERT(a_esc_has_head, !r_esc || !i_empty, "escape pending without entry")
    `EHFT_ASSERT(a_idx_two_bytes, !r_idx || (!i_empty && i_head.two_bytes),
        "second byte of single-byte entry")
    `EHFT_ASSERT_NEXT(a_pop_clears, o_pop, !r_idx && !r_esc, "walk state kept after pop")

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: escaped, hashed frame transmitter testbench
// Drives mode/byte transactions and register writes into the framer.
// Predicts line bytes, escaping, tlast and the running hash, and compares
// every output transaction against the oldest prediction. Traffic runs
// under several sender/receiver idling mixes and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned STALL_CYCLES  = 300;

    // indexes past the last register, writes there are dropped
    localparam logic [ehft_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [ehft_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [ehft_pkg::BYTE_W-1:0] line_byte;
        logic                        last_of_item;
    } t_line_beat;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [ehft_pkg::BYTE_W-1:0]    s_tdata     = '0;   // [7:0] value
    logic [ehft_pkg::MODE_W-1:0]    s_tuser     = '0;   // [1:0] mode
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [ehft_pkg::BYTE_W-1:0]    m_tdata;            // [7:0] line_byte
    logic                           m_tlast;            // last_of_item
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ehft_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ehft_pkg::BYTE_W-1:0]    i_cfg_data  = '0;

    // predictor state
    logic [ehft_pkg::BYTE_W-1:0] hash_lo  = ehft_pkg::HASH_START_LOW_RST;
    logic [ehft_pkg::BYTE_W-1:0] hash_hi  = ehft_pkg::HASH_START_HIGH_RST;
    logic [ehft_pkg::BYTE_W-1:0] start_lo = ehft_pkg::HASH_START_LOW_RST;
    logic [ehft_pkg::BYTE_W-1:0] start_hi = ehft_pkg::HASH_START_HIGH_RST;
    t_line_beat                  line_beats_q[$];
    t_line_beat                  expected_beat;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_cycles    = 0;
    int unsigned cycle_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned beats_checked  = 0;
    int unsigned reg_writes     = 0;
    int unsigned errors         = 0;

    escaped_hashed_frame_transmitter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d line bytes outstanding",
                     cycle_count, line_beats_q.size());
            $display("escaped_hashed_frame_transmitter test failed");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_tready = 1'b0;
            hold_cycles--;
        end else begin
            m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // line byte checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (line_beats_q.size() == 0) begin
                $error("line byte %02h with no transaction pending", m_tdata);
                errors++;
            end else begin
                expected_beat = line_beats_q.pop_front();
                beats_checked++;
                if (m_tdata !== expected_beat.line_byte) begin
                    $error("line_byte: expected %02h, got %02h",
                           expected_beat.line_byte, m_tdata);
                    errors++;
                end
                if (m_tlast !== expected_beat.last_of_item) begin
                    $error("last_of_item: expected %0b, got %0b",
                           expected_beat.last_of_item, m_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic bit needs_escape(input logic [ehft_pkg::BYTE_W-1:0] b);
        return (b == ehft_pkg::RESERVED_A) || (b == ehft_pkg::RESERVED_B) ||
               (b == ehft_pkg::RESERVED_C) || (b == ehft_pkg::ESC_BYTE);
    endfunction

    // computes the line bytes of one input transaction and advances the hash
    function automatic void predict_line_bytes(input logic [ehft_pkg::MODE_W-1:0] mode,
                                               input logic [ehft_pkg::BYTE_W-1:0] value);
        logic [ehft_pkg::BYTE_W-1:0] raw[$];
        logic [ehft_pkg::BYTE_W-1:0] wire_bytes[$];
        logic [ehft_pkg::BYTE_W-1:0] prod;
        t_line_beat                  beat;
        case (mode)
            ehft_pkg::MODE_DATA: begin
                raw.push_back(value);
                prod    = hash_lo * hash_hi;
                hash_hi = prod ^ hash_hi ^ value;
                hash_lo = prod ^ value;
            end
            ehft_pkg::MODE_FLAG: begin
                raw.push_back(value);
                raw.push_back(value);
            end
            ehft_pkg::MODE_HASH: begin
                raw.push_back(hash_lo);
                raw.push_back(hash_hi);
            end
            default: begin
                hash_lo = start_lo;
                hash_hi = start_hi;
            end
        endcase
        foreach (raw[i]) begin
            if (needs_escape(raw[i])) begin
                wire_bytes.push_back(ehft_pkg::ESC_BYTE);
                wire_bytes.push_back(raw[i] ^ ehft_pkg::ESC_BYTE);
            end else begin
                wire_bytes.push_back(raw[i]);
            end
        end
        foreach (wire_bytes[i]) begin
            beat.line_byte    = wire_bytes[i];
            beat.last_of_item = (i == wire_bytes.size() - 1);
            line_beats_q.push_back(beat);
        end
    endfunction

    // biased toward the escaped values
    function automatic logic [ehft_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(7))
            0:       return ehft_pkg::RESERVED_A;
            1:       return ehft_pkg::RESERVED_B;
            2:       return ehft_pkg::RESERVED_C;
            3:       return ehft_pkg::ESC_BYTE;
            default: return ehft_pkg::BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // entered and left at a falling edge; tvalid stays high for a following call
    task automatic send_item(input logic [ehft_pkg::MODE_W-1:0] mode,
                             input logic [ehft_pkg::BYTE_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = value;
        do @(posedge i_clk); while (!s_tready);
        predict_line_bytes(mode, value);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (line_beats_q.size() != 0) @(negedge i_clk);
    endtask

    // a restart leaves no output behind, so give it time to retire
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ehft_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ehft_pkg::BYTE_W-1:0]    data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ehft_pkg::REG_HASH_START_LOW) begin
            start_lo = data;
        end else if (idx == ehft_pkg::REG_HASH_START_HIGH) begin
            start_hi = data;
        end
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_reset_hash();
        send_item(ehft_pkg::MODE_HASH, 8'hA5);
        send_item(ehft_pkg::MODE_DATA, 8'h00);
        send_item(ehft_pkg::MODE_HASH, 8'h5A);
    endtask

    task automatic test_escaping();
        send_item(ehft_pkg::MODE_DATA, ehft_pkg::RESERVED_A);
        send_item(ehft_pkg::MODE_DATA, ehft_pkg::RESERVED_B);
        send_item(ehft_pkg::MODE_DATA, ehft_pkg::RESERVED_C);
        send_item(ehft_pkg::MODE_DATA, ehft_pkg::ESC_BYTE);
        send_item(ehft_pkg::MODE_DATA, 8'h00);
        send_item(ehft_pkg::MODE_DATA, 8'h1B);
        send_item(ehft_pkg::MODE_DATA, 8'hFE);
        send_item(ehft_pkg::MODE_DATA, 8'h80);
        send_item(ehft_pkg::MODE_DATA, 8'h7F);
        send_item(ehft_pkg::MODE_FLAG, ehft_pkg::ESC_BYTE);
        send_item(ehft_pkg::MODE_FLAG, ehft_pkg::RESERVED_B);
        send_item(ehft_pkg::MODE_FLAG, 8'h00);
        send_item(ehft_pkg::MODE_FLAG, 8'hAA);
        send_item(ehft_pkg::MODE_HASH, 8'hFF);
        send_item(ehft_pkg::MODE_RESTART, 8'hFF);
        send_item(ehft_pkg::MODE_HASH, 8'h00);
    endtask

    task automatic test_registers();
        wait_idle();
        write_reg(ehft_pkg::REG_HASH_START_LOW, ehft_pkg::RESERVED_C);
        write_reg(ehft_pkg::REG_HASH_START_HIGH, ehft_pkg::ESC_BYTE);
        // held hash is unaffected until the next restart
        send_item(ehft_pkg::MODE_HASH, 8'h00);
        send_item(ehft_pkg::MODE_RESTART, 8'h00);
        send_item(ehft_pkg::MODE_HASH, 8'h00);
        wait_idle();
        write_reg(REG_SPARE_2, 8'h00);
        write_reg(REG_SPARE_3, 8'hFF);
        send_item(ehft_pkg::MODE_RESTART, 8'h3C);
        send_item(ehft_pkg::MODE_HASH, 8'hC3);
        wait_idle();
        write_reg(ehft_pkg::REG_HASH_START_LOW, 8'h00);
        write_reg(ehft_pkg::REG_HASH_START_HIGH, 8'h00);
        send_item(ehft_pkg::MODE_RESTART, 8'h00);
        send_item(ehft_pkg::MODE_DATA, 8'h55);
        send_item(ehft_pkg::MODE_HASH, 8'h00);
    endtask

    task automatic test_random_traffic(input int unsigned src_pct,
                                       input int unsigned sink_pct,
                                       input int unsigned count);
        int unsigned sent;
        int unsigned len;
        wait_idle();
        write_reg(ehft_pkg::REG_HASH_START_LOW, pick_byte());
        write_reg(ehft_pkg::REG_HASH_START_HIGH, pick_byte());
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) < 8) begin
                // frame: optional restart, payload, optional flag, hash
                if ($urandom_range(1) == 1) begin
                    send_item(ehft_pkg::MODE_RESTART,
                              ehft_pkg::BYTE_W'($urandom_range(255)));
                    sent++;
                end
                len = $urandom_range(6, 1);
                repeat (len) begin
                    send_item(ehft_pkg::MODE_DATA, pick_byte());
                    sent++;
                end
                if ($urandom_range(3) == 0) begin
                    send_item(ehft_pkg::MODE_FLAG, pick_byte());
                    sent++;
                end
                send_item(ehft_pkg::MODE_HASH, ehft_pkg::BYTE_W'($urandom_range(255)));
                sent++;
            end else begin
                send_item(ehft_pkg::MODE_W'($urandom_range(3)), pick_byte());
                sent++;
            end
        end
    endtask

    task automatic test_output_stall();
        wait_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_cycles    = STALL_CYCLES;
        repeat (6) begin
            send_item(ehft_pkg::MODE_FLAG, pick_byte());
            send_item(ehft_pkg::MODE_DATA, pick_byte());
        end
        send_item(ehft_pkg::MODE_HASH, 8'h00);
        // sender waits for the backlog to clear
        wait_drained();
        send_item(ehft_pkg::MODE_HASH, 8'hFF);
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_hash();
        test_escaping();
        test_registers();
        test_random_traffic(0, 0, 22);
        test_random_traffic(88, 0, 20);
        test_random_traffic(0, 88, 20);
        test_random_traffic(20, 20, 20);
        test_output_stall();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("%0d input transactions, %0d line bytes checked, %0d register writes",
                 items_sent, beats_checked, reg_writes);
        $display("covered escaping, hash emit/restart, four idle mixes, long output stall");
        if (errors == 0) begin
            $display("escaped_hashed_frame_transmitter test passed");
        end else begin
            $display("escaped_hashed_frame_transmitter test failed");
        end
        $finish;
    end

endmodule
